FILE: rtl/core/bsbil_pkg.sv
`timescale 1ns / 1ps

package bsbil_pkg;

  // bitmap word geometry
  localparam int unsigned WordBits  = 64;
  localparam int unsigned BitIdxW   = 6;
  localparam int unsigned TakeW     = 7;

  // field widths
  localparam int unsigned IndexW    = 20;
  localparam int unsigned CountW    = 21;
  localparam int unsigned BaseW     = 22;

  // largest row count a run may ask for, larger counts saturate
  localparam logic [31:0] MAX_ROWS  = 32'd1048576;

  // input transaction payload
  typedef struct packed {
    logic [WordBits-1:0] word_bits;
    logic                first_word;
    logic [BitIdxW-1:0]  start_bit;
    logic [CountW-1:0]   row_count;
  } in_item_t;

  // result transaction payload
  typedef struct packed {
    logic [IndexW-1:0] index;
    logic              is_index;
    logic [CountW-1:0] found_count;
    logic              last_of_item;
    logic              run_end;
  } out_item_t;

  // controller states
  typedef enum logic [1:0] {
    ST_IDLE,
    ST_SCAN,
    ST_TERM
  } state_t;

  // controller to datapath
  typedef struct packed {
    logic load;
    logic emit_index;
    logic emit_term;
  } ctl_cmd_t;

  // datapath to controller
  typedef struct packed {
    logic word_active;
    logic word_has_bits;
    logic word_final;
    logic slot_free;
    logic bits_last;
  } ctl_stat_t;

endpackage

FILE: rtl/core/bitmap_set_bit_index_list_unit.sv
`timescale 1ns / 1ps

// Lists the set bits of a bitmap run as row indexes relative to the start row.
// Each input transaction is one 64-bit word; the first word of a run also gives
// the start bit and row count (counts above MAX_ROWS saturate). After a word is
// taken in, the block emits one result per cycle while the receiver takes them,
// for each set bit in range, lowest first, plus a terminator when the run's
// final word holds no set bits in range. Results pass through the single output
// register, which accepts one result per cycle unless a held result stalls it;
// a new word is taken as soon as the last result of the previous word has
// entered that register, even while it still waits to be taken. Words without
// first_word outside a run are taken and dropped.

module bitmap_set_bit_index_list_unit (
  input  logic                 clk,
  input  logic                 rst_n,
  input  logic                 in_valid,
  output logic                 in_ready,
  input  bsbil_pkg::in_item_t  in_data,
  output logic                 out_valid,
  input  logic                 out_ready,
  output bsbil_pkg::out_item_t out_data
);
  import bsbil_pkg::*;

  ctl_cmd_t  cmd;
  ctl_stat_t stat;

  // sequencer
  bsbil_ctrl u_ctrl (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_valid),
    .in_ready (in_ready),
    .stat     (stat),
    .cmd      (cmd)
  );

  // run state, bit scan and output register
  bsbil_dp u_dp (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_data   (in_data),
    .cmd       (cmd),
    .stat      (stat),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .out_data  (out_data)
  );

endmodule

FILE: rtl/core/bsbil_ctrl.sv
`timescale 1ns / 1ps

module bsbil_ctrl (
  input  logic                 clk,
  input  logic                 rst_n,
  input  logic                 in_valid,
  output logic                 in_ready,
  input  bsbil_pkg::ctl_stat_t stat,
  output bsbil_pkg::ctl_cmd_t  cmd
);
  import bsbil_pkg::*;

  state_t state_r;
  state_t state_nxt;

  // state register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= ST_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

  // next state
  always_comb begin
    state_nxt = state_r;
    case (state_r)
      ST_IDLE: begin
        if (in_valid && stat.word_active) begin
          if (stat.word_has_bits) begin
            state_nxt = ST_SCAN;
          end else if (stat.word_final) begin
            state_nxt = ST_TERM;
          end
        end
      end
      ST_SCAN: begin
        if (stat.slot_free && stat.bits_last) begin
          state_nxt = ST_IDLE;
        end
      end
      ST_TERM: begin
        if (stat.slot_free) begin
          state_nxt = ST_IDLE;
        end
      end
      default: begin
        state_nxt = ST_IDLE;
      end
    endcase
  end

  // outputs
  always_comb begin
    in_ready       = 1'b0;
    cmd.load       = 1'b0;
    cmd.emit_index = 1'b0;
    cmd.emit_term  = 1'b0;
    case (state_r)
      ST_IDLE: begin
        in_ready = 1'b1;
        cmd.load = in_valid;
      end
      ST_SCAN: begin
        cmd.emit_index = stat.slot_free;
      end
      ST_TERM: begin
        cmd.emit_term = stat.slot_free;
      end
      default: begin
        in_ready = 1'b0;
      end
    endcase
  end

endmodule

FILE: rtl/core/bsbil_dp.sv
`timescale 1ns / 1ps

module bsbil_dp (
  input  logic                 clk,
  input  logic                 rst_n,
  input  bsbil_pkg::in_item_t  in_data,
  input  bsbil_pkg::ctl_cmd_t  cmd,
  output bsbil_pkg::ctl_stat_t stat,
  output logic                 out_valid,
  input  logic                 out_ready,
  output bsbil_pkg::out_item_t out_data
);
  import bsbil_pkg::*;

  // run state
  logic [BaseW-1:0]    word_base_r, word_base_nxt;
  logic [CountW-1:0]   rows_left_r, rows_left_nxt;
  logic [CountW-1:0]   count_r;
  logic                in_run_r;

  // per-word scan state
  logic [WordBits-1:0] bits_r;
  logic [BitIdxW-1:0]  lo_r;
  logic [BaseW-1:0]    base_r;
  logic                final_r;

  // output register
  logic                out_valid_r;
  out_item_t           out_r;

  // load-side signals
  logic [BitIdxW-1:0]  lo_w;
  logic [CountW-1:0]   rc_sat;
  logic [CountW-1:0]   rl_w;
  logic [BaseW-1:0]    base_w;
  logic [TakeW-1:0]    avail_w;
  logic [TakeW-1:0]    take_w;
  logic [WordBits-1:0] low_ones;
  logic [WordBits-1:0] mask_w;
  logic [WordBits-1:0] bits_w;

  // scan-side signals
  logic [BitIdxW-1:0]  bit_pos;
  logic [WordBits-1:0] bits_rest;
  logic [CountW-1:0]   count_inc;
  logic [IndexW-1:0]   index_w;

  // range of rows this word covers
  always_comb begin
    rc_sat = in_data.row_count;
    if ({11'b0, in_data.row_count} > MAX_ROWS) begin
      rc_sat = MAX_ROWS[CountW-1:0];
    end
    lo_w          = in_data.first_word ? in_data.start_bit : '0;
    rl_w          = in_data.first_word ? rc_sat : rows_left_r;
    base_w        = in_data.first_word ? '0 : word_base_r;
    avail_w       = TakeW'(WordBits) - {1'b0, lo_w};
    take_w        = (rl_w < {{(CountW-TakeW){1'b0}}, avail_w}) ? rl_w[TakeW-1:0] : avail_w;
    low_ones      = (take_w >= TakeW'(WordBits)) ? '1 : ((64'd1 << take_w) - 64'd1);
    mask_w        = low_ones << lo_w;
    bits_w        = in_data.word_bits & mask_w;
    rows_left_nxt = rl_w - {{(CountW-TakeW){1'b0}}, take_w};
    word_base_nxt = base_w + {{(BaseW-TakeW){1'b0}}, take_w};
  end

  // lowest set bit of the pending word
  always_comb begin
    bit_pos = '0;
    for (int i = WordBits - 1; i >= 0; i--) begin
      if (bits_r[i]) begin
        bit_pos = BitIdxW'(i);
      end
    end
    bits_rest = bits_r & (bits_r - 64'd1);
    count_inc = count_r + 21'd1;
    index_w   = base_r[IndexW-1:0] + {{(IndexW-BitIdxW){1'b0}}, bit_pos - lo_r};
  end

  // status to controller
  always_comb begin
    stat.word_active   = in_data.first_word || in_run_r;
    stat.word_has_bits = (bits_w != '0);
    stat.word_final    = (rows_left_nxt == '0);
    stat.slot_free     = !out_valid_r || out_ready;
    stat.bits_last     = (bits_rest == '0);
  end

  // run control state
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      word_base_r <= '0;
      rows_left_r <= '0;
      count_r     <= '0;
      in_run_r    <= 1'b0;
    end else if (cmd.load && stat.word_active) begin
      word_base_r <= word_base_nxt;
      rows_left_r <= rows_left_nxt;
      in_run_r    <= (rows_left_nxt != '0);
      if (in_data.first_word) begin
        count_r <= '0;
      end
    end else if (cmd.emit_index) begin
      count_r <= count_inc;
    end
  end

  // pending word for the scan
  always_ff @(posedge clk) begin
    if (cmd.load && stat.word_active) begin
      bits_r  <= bits_w;
      lo_r    <= lo_w;
      base_r  <= base_w;
      final_r <= (rows_left_nxt == '0);
    end else if (cmd.emit_index) begin
      bits_r <= bits_rest;
    end
  end

  // output valid flag
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (cmd.emit_index || cmd.emit_term) begin
      out_valid_r <= 1'b1;
    end else if (out_ready) begin
      out_valid_r <= 1'b0;
    end
  end

  // output payload
  always_ff @(posedge clk) begin
    if (cmd.emit_index) begin
      out_r.index        <= index_w;
      out_r.is_index     <= 1'b1;
      out_r.found_count  <= count_inc;
      out_r.last_of_item <= (bits_rest == '0);
      out_r.run_end      <= (bits_rest == '0) && final_r;
    end else if (cmd.emit_term) begin
      out_r.index        <= '0;
      out_r.is_index     <= 1'b0;
      out_r.found_count  <= count_r;
      out_r.last_of_item <= 1'b1;
      out_r.run_end      <= 1'b1;
    end
  end

  assign out_valid = out_valid_r;
  assign out_data  = out_r;

endmodule

FILE: rtl/core/bsbil_checker.sv
`timescale 1ns / 1ps

module bsbil_checker (
  input logic                 clk,
  input logic                 rst_n,
  input logic                 in_valid,
  input logic                 in_ready,
  input bsbil_pkg::in_item_t  in_data,
  input logic                 out_valid,
  input logic                 out_ready,
  input bsbil_pkg::out_item_t out_data
);
  import bsbil_pkg::*;

  // a waiting input transaction holds
  a_in_hold: assert property (@(posedge clk) disable iff (!rst_n)
    in_valid && !in_ready |=> in_valid && $stable(in_data))
    else $error("input changed while waiting");

  // a stalled result holds
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_ready |=> out_valid && $stable(out_data))
    else $error("result changed while stalled");

  // terminator closes the word and the run and carries a zero index
  a_term_ends: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_data.is_index |->
      out_data.last_of_item && out_data.run_end && out_data.index == '0)
    else $error("malformed terminator");

  // run end is always the last result of its word
  a_end_last: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_data.run_end |-> out_data.last_of_item)
    else $error("run_end without last_of_item");

  // an index result has counted itself
  a_count_nz: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_data.is_index |-> out_data.found_count != '0)
    else $error("index result with zero count");

endmodule

bind bitmap_set_bit_index_list_unit bsbil_checker u_bsbil_checker (
  .clk       (clk),
  .rst_n     (rst_n),
  .in_valid  (in_valid),
  .in_ready  (in_ready),
  .in_data   (in_data),
  .out_valid (out_valid),
  .out_ready (out_ready),
  .out_data  (out_data)
);

FILE: tb/sv/tb_bitmap_set_bit_index_list_unit.sv
`timescale 1ns / 1ps

module tb_bitmap_set_bit_index_list_unit;
  import bsbil_pkg::*;

  // follows the run state and queues the results each accepted word should cause
  class index_list_model;
    logic [BaseW-1:0]  word_base;
    logic [CountW-1:0] rows_left;
    logic [CountW-1:0] found;
    logic              in_run;
    out_item_t         pending_entries[$];
    int unsigned       errors;

    function new();
      word_base = '0;
      rows_left = '0;
      found     = '0;
      in_run    = 1'b0;
      errors    = 0;
    endfunction

    // returns 1 when the word belongs to a run, 0 when the block drops it
    function bit accept_word(in_item_t w);
      logic [BitIdxW-1:0]  lo;
      logic [TakeW-1:0]    avail;
      logic [TakeW-1:0]    take;
      logic [WordBits-1:0] mask;
      logic [WordBits-1:0] hits;
      logic [BaseW-1:0]    rel;
      logic                last_word;
      logic                have;
      out_item_t           entry;
      int                  b;
      if (w.first_word) begin
        rows_left = (w.row_count > MAX_ROWS) ? CountW'(MAX_ROWS) : w.row_count;
        lo        = w.start_bit;
        word_base = '0;
        found     = '0;
        in_run    = 1'b1;
      end else if (!in_run) begin
        return 1'b0;
      end else begin
        lo = '0;
      end

      // rows of this word that fall inside the run
      avail = TakeW'(WordBits) - TakeW'(lo);
      take  = (rows_left < CountW'(avail)) ? TakeW'(rows_left) : avail;
      if (take == '0) begin
        mask = '0;
      end else if (take == TakeW'(WordBits)) begin
        mask = '1;
      end else begin
        mask = ((WordBits'(1) << take) - WordBits'(1)) << lo;
      end
      hits      = w.word_bits & mask;
      rows_left = rows_left - CountW'(take);
      last_word = (rows_left == '0);

      // one entry per set bit, lowest first; the last one is held back to mark it
      have  = 1'b0;
      entry = '0;
      for (b = 0; b < WordBits; b++) begin
        if (hits[b]) begin
          if (have) begin
            pending_entries.push_back(entry);
          end
          found             = found + 1'b1;
          rel               = word_base + BaseW'(b) - BaseW'(lo);
          entry             = '0;
          entry.index       = rel[IndexW-1:0];
          entry.is_index    = 1'b1;
          entry.found_count = found;
          have              = 1'b1;
        end
      end
      if (have) begin
        entry.last_of_item = 1'b1;
        entry.run_end      = last_word;
        pending_entries.push_back(entry);
      end else if (last_word) begin
        // terminator carries the run total
        entry              = '0;
        entry.found_count  = found;
        entry.last_of_item = 1'b1;
        entry.run_end      = 1'b1;
        pending_entries.push_back(entry);
      end

      word_base = word_base + BaseW'(take);
      if (last_word) begin
        in_run = 1'b0;
      end
      return 1'b1;
    endfunction

    function void compare_field(string name, int unsigned want_v, int unsigned got_v);
      if (want_v != got_v) begin
        errors++;
        $display("%0t: %s mismatch, expected %0h, actual %0h", $time, name, want_v, got_v);
      end
    endfunction

    // compares one accepted result with the oldest queued entry
    function void check_entry(out_item_t got);
      out_item_t want;
      if (pending_entries.size() == 0) begin
        errors++;
        $display("%0t: unexpected result, expected none, actual %h", $time, got);
        return;
      end
      want = pending_entries.pop_front();
      compare_field("index", want.index, got.index);
      compare_field("is_index", want.is_index, got.is_index);
      compare_field("found_count", want.found_count, got.found_count);
      compare_field("last_of_item", want.last_of_item, got.last_of_item);
      compare_field("run_end", want.run_end, got.run_end);
    endfunction
  endclass

  localparam int unsigned TotalWords  = 470;
  localparam int unsigned QuietFrom   = 410;
  localparam int unsigned HoldCycles  = 600;
  localparam int unsigned DrainCycles = 80;

  logic      clk       = 1'b0;
  logic      rst_n     = 1'b0;
  logic      in_valid  = 1'b0;
  logic      in_ready;
  in_item_t  in_data   = '0;
  logic      out_valid;
  logic      out_ready = 1'b0;
  out_item_t out_data;

  index_list_model tracker = new();
  bit              quiet     = 1'b0;
  bit              hold_req  = 1'b0;
  int unsigned     run_words = 0;

  bitmap_set_bit_index_list_unit u_dut (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_ready  (in_ready),
    .in_data   (in_data),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .out_data  (out_data)
  );

  // 10 ns clock
  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  // result transactions go to the tracker
  always @(posedge clk) begin
    if (rst_n && out_valid && out_ready) begin
      tracker.check_entry(out_data);
    end
  end

  // receiver: random ready bursts, one long hold-off, always ready near the end
  initial begin : receiver
    wait (rst_n);
    @(posedge clk);
    forever begin
      if (hold_req) begin
        hold_req = 1'b0;
        out_ready <= 1'b0;
        repeat (HoldCycles) @(posedge clk);
      end else if (!quiet && $urandom_range(0, 3) == 0) begin
        out_ready <= 1'b0;
        repeat ($urandom_range(1, 16)) @(posedge clk);
      end else begin
        out_ready <= 1'b1;
        repeat (quiet ? 1 : $urandom_range(1, 16)) @(posedge clk);
      end
    end
  end

  function automatic logic [WordBits-1:0] rand64();
    return {$urandom, $urandom};
  endfunction

  // word contents of varying density
  function automatic logic [WordBits-1:0] rand_bits();
    case ($urandom_range(0, 7))
      0:       return '0;
      1:       return '1;
      2:       return rand64() & rand64() & rand64();
      3:       return rand64() | rand64();
      4:       return WordBits'(1) << $urandom_range(0, WordBits - 1);
      default: return rand64();
    endcase
  endfunction

  function automatic in_item_t make_word(logic first, logic [BitIdxW-1:0] sbit,
                                         logic [CountW-1:0] rows, logic [WordBits-1:0] bits);
    in_item_t w;
    w.word_bits  = bits;
    w.first_word = first;
    w.start_bit  = sbit;
    w.row_count  = rows;
    return w;
  endfunction

  // words needed to cover a run that does not saturate
  function automatic int unsigned run_length(int unsigned sbit, int unsigned rows);
    if (rows == 0) begin
      return 1;
    end
    return (sbit + rows + WordBits - 1) / WordBits;
  endfunction

  // offers one input transaction, after an optional idle burst
  task automatic send_word(in_item_t w);
    int unsigned gap;
    gap = 0;
    if (!quiet && $urandom_range(0, 3) == 0) begin
      gap = $urandom_range(1, 16);
    end
    if (gap != 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_valid <= 1'b1;
    in_data  <= w;
    do @(posedge clk); while (!in_ready);
    if (tracker.accept_word(w)) begin
      run_words++;
    end
  endtask

  // first word of a run, then continuation words with random ignored fields
  task automatic send_run(logic [BitIdxW-1:0] sbit, logic [CountW-1:0] rows,
                          int unsigned words);
    int unsigned k;
    send_word(make_word(1'b1, sbit, rows, rand_bits()));
    for (k = 1; k < words; k++) begin
      send_word(make_word(1'b0, BitIdxW'($urandom), CountW'($urandom), rand_bits()));
    end
  endtask

  initial begin : stimulus
    int unsigned       pick;
    logic [BitIdxW-1:0] sbit;
    logic [CountW-1:0]  rows;

    repeat (6) @(posedge clk);
    rst_n <= 1'b1;

    // word outside any run is dropped
    send_word(make_word(1'b0, 6'd9, 21'd100, '1));
    // full word of set bits
    send_word(make_word(1'b1, 6'd0, 21'd64, '1));
    // zero-length run still takes one word and ends with a terminator
    send_word(make_word(1'b1, 6'd17, 21'd0, '1));
    // single row at the top bit, set then clear
    send_word(make_word(1'b1, 6'd63, 21'd1, 64'h8000_0000_0000_0000));
    send_word(make_word(1'b1, 6'd63, 21'd1, 64'h7FFF_FFFF_FFFF_FFFF));
    // three-word run with an empty word in the middle
    send_word(make_word(1'b1, 6'd5, 21'd130, '1));
    send_word(make_word(1'b0, 6'd0, 21'd0, '0));
    send_word(make_word(1'b0, 6'd63, 21'h1FFFFF, 64'h8000_0000_0000_0001));
    // oversized row count saturates, then the run is abandoned
    send_word(make_word(1'b1, 6'd0, 21'h1FFFFF, '1));
    send_word(make_word(1'b0, 6'd0, 21'd0, 64'hA5A5_5A5A_0F0F_F0F0));
    // new run mid-run; its final word has no set bits in range
    send_word(make_word(1'b1, 6'd32, 21'd40, '1));
    send_word(make_word(1'b0, 6'd0, 21'd0, 64'h0000_0000_FFFF_FF00));
    // exact maximum row count, abandoned after two words
    send_word(make_word(1'b1, 6'd0, CountW'(MAX_ROWS), rand64()));
    send_word(make_word(1'b0, 6'd0, 21'd0, rand64()));
    // range ending one below the top bit, and exactly at it
    send_word(make_word(1'b1, 6'd0, 21'd63, '1));
    send_word(make_word(1'b1, 6'd40, 21'd24, '1));
    // dropped again once the run is over
    send_word(make_word(1'b0, 6'd63, 21'h1FFFFF, '1));

    // random part opens with a long receiver hold-off
    hold_req = 1'b1;
    while (run_words < TotalWords) begin
      if (run_words >= QuietFrom) begin
        quiet = 1'b1;
      end
      pick = $urandom_range(0, 19);
      sbit = BitIdxW'($urandom);
      if (pick < 15) begin
        // complete run of small size
        if ($urandom_range(0, 9) == 0) begin
          rows = CountW'($urandom_range(0, 8));
        end else begin
          rows = CountW'($urandom_range(1, 320));
        end
        send_run(sbit, rows, run_length(sbit, rows));
      end else if (pick < 18) begin
        // run that may be cut short by the next first word
        case ($urandom_range(0, 3))
          0:       rows = CountW'(MAX_ROWS);
          1:       rows = CountW'($urandom_range(65, 2000));
          default: rows = CountW'($urandom);
        endcase
        send_run(sbit, rows, $urandom_range(1, 4));
      end else begin
        // continuation word, dropped unless a run is open
        send_word(make_word(1'b0, sbit, CountW'($urandom), rand_bits()));
      end
    end
    in_valid <= 1'b0;

    while (tracker.pending_entries.size() != 0) @(posedge clk);
    repeat (DrainCycles) @(posedge clk);
    if (tracker.errors == 0 && tracker.pending_entries.size() == 0) begin
      $display("Test completed successfully");
    end else begin
      $display("Test completed with failures");
    end
    $finish;
  end

  // run limit
  initial begin : watchdog
    #20_000_000;
    $display("Test completed with failures");
    $finish;
  end

endmodule
